>>> hdl/pmo_pkg.sv
// ----------------------------------------------------------------------------
// pmo_pkg
// Types, constants and command/status structs for the Prewitt gradient unit.
// ----------------------------------------------------------------------------
package pmo_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 12;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    localparam logic [10:0] WIDTH_RESET  = 11'd640;
    localparam logic [11:0] HEIGHT_RESET = 12'd480;

    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_start;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] magnitude;
        logic [7:0] angle_degrees;
        logic       frame_end;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_WIN,
        ST_CALC,
        ST_OUT
    } t_state;

    // Controller -> datapath commands.
    typedef struct packed {
        logic load_in;   // capture input beat, update position
        logic mem_rd;    // line store read / write
        logic win_upd;   // shift window, form sums
        logic calc_init; // start iterative units
        logic calc_step; // one iteration
        logic out_load;  // move result into output register
    } t_cmd;

    // Datapath -> controller status.
    typedef struct packed {
        logic interior;  // current pixel yields a result
        logic calc_done;
    } t_sts;

    // atan(2^-i) in degrees, Q16.
    function automatic logic [21:0] atan_q16(input logic [3:0] i);
        logic [21:0] v;
        begin
            unique case (i)
                4'd0:  v = 22'd2949120;
                4'd1:  v = 22'd1740967;
                4'd2:  v = 22'd919879;
                4'd3:  v = 22'd466945;
                4'd4:  v = 22'd234379;
                4'd5:  v = 22'd117304;
                4'd6:  v = 22'd58666;
                4'd7:  v = 22'd29335;
                4'd8:  v = 22'd14668;
                4'd9:  v = 22'd7334;
                4'd10: v = 22'd3667;
                4'd11: v = 22'd1833;
                4'd12: v = 22'd917;
                4'd13: v = 22'd458;
                4'd14: v = 22'd229;
                default: v = 22'd115;
            endcase
            return v;
        end
    endfunction

endpackage

>>> hdl/prewitt_magnitude_orientation_unit.sv
// An interior pixel's result passes from the input beat through the line store read, the window
// update and the iterative units into the output register; border pixels give no result.
// One pixel is taken at a time, set by the 16-step shared CORDIC / square-root unit and
// the single line store port; a result waiting for a free output slot also holds the unit.
// Output register lets the next pixel be taken while the result waits.
// Reset (sync, active low): position and window zero, width 640, height 480.
// ----------------------------------------------------------------------------
// prewitt_magnitude_orientation_unit
// Streaming 3x3 Prewitt gradient: magnitude and orientation per interior pixel.
// ----------------------------------------------------------------------------
module prewitt_magnitude_orientation_unit
    import pmo_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_beat              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_beat             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    logic [10:0] r_width;
    logic [11:0] r_height;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WIDTH:  r_width  <= i_cfg_data[10:0];
                REG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    t_cmd      cmd;
    t_sts      sts;
    t_out_beat res;
    logic      out_free;

    // output register: free when empty or being taken this cycle
    logic      r_out_valid;
    t_out_beat r_out_data;
    assign out_free = !r_out_valid || !i_out_stall;

    pmo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pmo_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_in     (i_in_data),
        .i_width  (r_width),
        .i_height (r_height),
        .o_sts    (sts),
        .o_res    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.out_load) r_out_data <= res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // result only loaded when the output slot is free
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> out_free) else $error("result loaded over pending beat");

    // angle never exceeds 180
    a_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.angle_degrees <= 8'd180))
        else $error("angle out of range");

    // input taken only while controller is not busy
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_in |=> o_in_stall) else $error("second item accepted while busy");

endmodule

>>> hdl/pmo_ctrl.sv
// ----------------------------------------------------------------------------
// pmo_ctrl
// Sequencer: accept, line store access, window, iterate, present result.
// ----------------------------------------------------------------------------
module pmo_ctrl
    import pmo_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_stall,
    input  logic   i_out_free,
    input  t_sts   i_sts,
    output t_cmd   o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_READ;
            ST_READ: n_state = ST_WIN;
            ST_WIN:  n_state = i_sts.interior ? ST_CALC : ST_IDLE;
            ST_CALC: if (i_sts.calc_done) n_state = ST_OUT;
            ST_OUT:  if (i_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.load_in = i_in_valid;
            end
            ST_READ: o_cmd.mem_rd = 1'b1;
            ST_WIN: begin
                o_cmd.win_upd   = 1'b1;
                o_cmd.calc_init = i_sts.interior;
            end
            ST_CALC: o_cmd.calc_step = 1'b1;
            ST_OUT:  o_cmd.out_load  = i_out_free;
            default: ;
        endcase
    end

endmodule

>>> hdl/pmo_datapath.sv
// ----------------------------------------------------------------------------
// pmo_datapath
// Line stores, 3x3 window, Prewitt sums, bitwise square root, CORDIC angle.
// ----------------------------------------------------------------------------
module pmo_datapath
    import pmo_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  t_in_beat    i_in,
    input  logic [10:0] i_width,
    input  logic [11:0] i_height,
    output t_sts        o_sts,
    output t_out_beat   o_res
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // effective geometry
    logic [11:0] w_eff, h_eff;
    always_comb begin
        if (i_width < 11'd3)
            w_eff = 12'd3;
        else if (32'(i_width) > MAX_WIDTH)
            w_eff = 12'(MAX_WIDTH);
        else
            w_eff = {1'b0, i_width};
        h_eff = (i_height < 12'd3) ? 12'd3 : i_height;
    end

    logic [7:0]  r_px;
    logic [11:0] r_col, r_row, r_c, r_r;
    logic        r_last;
    logic [11:0] c_now, r_now;

    always_comb begin
        c_now = i_in.frame_start ? 12'd0 : r_col;
        r_now = i_in.frame_start ? 12'd0 : r_row;
        if (c_now >= w_eff) c_now = 12'd0;
        if (r_now >= h_eff) r_now = 12'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.load_in) begin
            if (c_now + 12'd1 >= w_eff) begin
                r_col <= '0;
                r_row <= (r_now + 12'd1 >= h_eff) ? 12'd0 : r_now + 12'd1;
            end else begin
                r_col <= c_now + 12'd1;
                r_row <= r_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_px   <= i_in.pixel;
            r_c    <= c_now;
            r_r    <= r_now;
            r_last <= (r_now == h_eff - 12'd1) && (c_now == w_eff - 12'd1);
        end
    end

    // line stores: read then write same address in the same cycle
    logic [7:0] mem_up  [MAX_WIDTH];
    logic [7:0] mem_mid [MAX_WIDTH];
    logic [7:0] r_up, r_mid;
    logic [AW-1:0] addr;
    assign addr = r_c[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_up          <= mem_up[addr];
            r_mid         <= mem_mid[addr];
            mem_up[addr]  <= mem_mid[addr];
            mem_mid[addr] <= r_px;
        end
    end

    // window [row][col], col 2 newest
    logic [7:0] r_win [3][3];
    logic signed [10:0] gx_n, gy_n;
    always_comb begin
        gx_n = 11'sd0;
        gy_n = 11'sd0;
        gx_n = $signed({3'b0, r_up}) + $signed({3'b0, r_mid}) + $signed({3'b0, r_px})
             - $signed({3'b0, r_win[0][1]}) - $signed({3'b0, r_win[1][1]})
             - $signed({3'b0, r_win[2][1]});
        gy_n = $signed({3'b0, r_win[2][1]}) + $signed({3'b0, r_win[2][2]})
             + $signed({3'b0, r_px})
             - $signed({3'b0, r_win[0][1]}) - $signed({3'b0, r_win[0][2]})
             - $signed({3'b0, r_up});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++)
                for (int j = 0; j < 3; j++)
                    r_win[k][j] <= '0;
        end else if (i_cmd.win_upd) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= r_win[k][1];
                r_win[k][1] <= r_win[k][2];
            end
            r_win[0][2] <= r_up;
            r_win[1][2] <= r_mid;
            r_win[2][2] <= r_px;
        end
    end

    assign o_sts.interior = (r_r >= 12'd2) && (r_c >= 12'd2);

    // iterative units
    logic [20:0] r_s;
    logic [7:0]  r_m;
    logic signed [27:0] r_x, r_y;
    logic signed [24:0] r_z;
    logic [3:0]  r_it;
    logic        r_fix;
    logic [7:0]  r_fix_ang;
    logic        r_done, r_fe;

    logic [9:0]  agx, agy;
    logic [20:0] sq_sum;
    logic        fix;
    logic [7:0]  fix_ang;
    always_comb begin
        agx    = gx_n[10] ? 10'(-gx_n) : gx_n[9:0];
        agy    = gy_n[10] ? 10'(-gy_n) : gy_n[9:0];
        sq_sum = 21'(agx) * 21'(agx) + 21'(agy) * 21'(agy);
        fix = 1'b1;
        if (agy == 10'd0)      fix_ang = gx_n[10] ? 8'd180 : 8'd0;
        else if (agx == 10'd0) fix_ang = 8'd90;
        else if (agx == agy)   fix_ang = gx_n[10] ? 8'd135 : 8'd45;
        else begin
            fix     = 1'b0;
            fix_ang = 8'd0;
        end
    end

    logic [7:0]  trial;
    logic [22:0] tsq;
    logic [2:0]  bidx;
    logic signed [27:0] xs, ys;
    logic [21:0] at;
    assign bidx  = 3'(3'd7 - r_it[2:0]);
    assign trial = r_m | (8'd1 << bidx);
    assign tsq   = 23'(18 * 32'(trial) * 32'(trial));
    assign xs    = r_x >>> r_it;
    assign ys    = r_y >>> r_it;
    assign at    = atan_q16(r_it);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else if (i_cmd.calc_init) begin
            r_done <= 1'b0;
        end else if (i_cmd.calc_step && r_it == 4'd15) begin
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_init) begin
            r_s       <= sq_sum;
            r_m       <= '0;
            r_it      <= '0;
            r_fix     <= fix;
            r_fix_ang <= fix_ang;
            r_fe      <= r_last;
            if (gx_n[10]) begin
                r_x <= 28'(agy) <<< 16;
                r_y <= 28'(agx) <<< 16;
                r_z <= 25'sd5898240;
            end else begin
                r_x <= 28'(agx) <<< 16;
                r_y <= 28'(agy) <<< 16;
                r_z <= '0;
            end
        end else if (i_cmd.calc_step && !r_done) begin
            r_it <= r_it + 4'd1;
            if (r_it < 4'd8 && {2'd0, r_s} >= tsq)
                r_m <= trial;
            if (!r_y[27]) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + $signed({3'b0, at});
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - $signed({3'b0, at});
            end
        end
    end
    assign o_sts.calc_done = r_done;

    logic [7:0] ang;
    always_comb begin
        if (r_fix)                 ang = r_fix_ang;
        else if (r_z[24])          ang = 8'd0;
        else if (r_z[24:16] > 9'd180) ang = 8'd180;
        else                       ang = r_z[23:16];
    end

    assign o_res.magnitude     = r_m;
    assign o_res.angle_degrees = ang;
    assign o_res.frame_end     = r_fe;

endmodule
